[hdl/cdoy_pkg.sv]
// Shared types, widths and calendar tables for the day-of-year converter.
package cdoy_pkg;

    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    localparam logic [15:0] MaxYear   = 16'd9999;
    localparam logic [7:0]  MaxDay    = 8'd31;
    localparam logic [7:0]  MaxMonth  = 8'd12;
    localparam logic [3:0]  LastMonth = 4'd11;
    localparam logic [8:0]  YearLen   = 9'd365;
    localparam logic [8:0]  LeapLen   = 9'd366;

    typedef enum logic
    {
        KIND_TO_DAY  = 1'b0,
        KIND_TO_DATE = 1'b1
    } cdoy_kind_t;

    typedef struct packed
    {
        cdoy_kind_t  kind;
        logic [7:0]  mday;
        logic [7:0]  month;
        logic [15:0] year;
        logic [8:0]  day_of_year;
    } cdoy_req_t;

    typedef struct packed
    {
        logic [8:0] day_number;
        logic [3:0] month_number;
        logic [4:0] day_in_month;
        logic       valid_res;
    } cdoy_result_t;

    // Days in the months before month m0 (0-based).
    function automatic logic [8:0] days_before(input logic [3:0] m0, input logic leap);
        logic [8:0] base;
        begin
            unique case (m0)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && m0 >= 4'd2 && m0 <= LastMonth)
                base = base + 9'd1;
            return base;
        end
    endfunction

    // Length of month m0 (0-based); zero past December.
    function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
        logic [4:0] len;
        begin
            unique case (m0)
                4'd1:                         len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
                4'd0, 4'd2, 4'd4, 4'd6,
                4'd7, 4'd9, 4'd11:            len = 5'd31;
                default:                      len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

[hdl/cdoy_conv.sv]
// Combinational date <-> day-of-year conversion for one request.
module cdoy_conv
(
    input  cdoy_pkg::cdoy_req_t    req,
    output cdoy_pkg::cdoy_result_t res
);

    logic       leap;
    logic [3:0] dom_m0;
    logic       date_ok;
    logic [8:0] ylen;
    logic       doy_ok;
    logic [3:0] find_m0;
    logic [8:0] rest;

    assign leap   = (req.year[1:0] == 2'b00);
    assign dom_m0 = 4'(req.month - 8'd1);

    assign date_ok = (req.mday >= 8'd1) && (req.mday <= cdoy_pkg::MaxDay)
                  && (req.month >= 8'd1) && (req.month <= cdoy_pkg::MaxMonth)
                  && (req.year <= cdoy_pkg::MaxYear)
                  && (req.mday <= {3'd0, cdoy_pkg::month_len(dom_m0, leap)});

    assign ylen   = leap ? cdoy_pkg::LeapLen : cdoy_pkg::YearLen;
    assign doy_ok = (req.day_of_year >= 9'd1) && (req.day_of_year <= ylen);

    // Month whose span holds the day: count month ends below it, capped at December.
    always_comb
    begin
        find_m0 = 4'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (req.day_of_year > cdoy_pkg::days_before(4'(i + 1), leap))
                find_m0 = 4'(i + 1);
        end
    end

    assign rest = req.day_of_year - cdoy_pkg::days_before(find_m0, leap);

    always_comb
    begin
        res = '0;
        unique case (req.kind)
            cdoy_pkg::KIND_TO_DAY:
            begin
                if (date_ok)
                begin
                    res.day_number = cdoy_pkg::days_before(dom_m0, leap)
                                   + {1'b0, req.mday};
                    res.valid_res  = 1'b1;
                end
            end
            cdoy_pkg::KIND_TO_DATE:
            begin
                if (doy_ok)
                begin
                    res.month_number = find_m0 + 4'd1;
                    res.day_in_month = rest[4:0];
                    res.valid_res    = 1'b1;
                end
            end
            default: res = '0;
        endcase
    end

endmodule

[hdl/calendar_day_of_year_converter.sv]
// Top level: streaming date <-> day-of-year converter with input and result registers.
// Takes one request word per cycle unless the master side stalls, and returns one result
// word per request, in order. An accepted word goes into the input register, passes
// through the combinational conversion logic into the result register and leaves the
// master side from there. With the master side always ready the block sustains one word
// every cycle; a stall on the master side holds the result, and one more word can still
// be taken into the input register before the slave side backs up.
module calendar_day_of_year_converter
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] mday, [15:8] month, [31:16] year, [40:32] day_of_year, rest zero
    input  logic [cdoy_pkg::InDataW-1:0]  s_axis_tdata,
    // [0] kind
    input  logic                          s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [8:0] day_number, [12:9] month_number, [17:13] day_in_month, rest zero
    output logic [cdoy_pkg::OutDataW-1:0] m_axis_tdata,
    // [0] valid_res
    output logic                          m_axis_tuser
);

    logic                   in_valid_reg;
    cdoy_pkg::cdoy_req_t    in_reg;
    cdoy_pkg::cdoy_req_t    in_next;
    logic                   out_valid_reg;
    cdoy_pkg::cdoy_result_t out_reg;
    cdoy_pkg::cdoy_result_t out_next;
    logic                   out_en;
    logic                   in_en;

    assign out_en = !out_valid_reg || m_axis_tready;
    assign in_en  = !in_valid_reg || out_en;

    assign s_axis_tready = in_en;

    always_comb
    begin
        in_next.kind        = cdoy_pkg::cdoy_kind_t'(s_axis_tuser);
        in_next.mday        = s_axis_tdata[7:0];
        in_next.month       = s_axis_tdata[15:8];
        in_next.year        = s_axis_tdata[31:16];
        in_next.day_of_year = s_axis_tdata[40:32];
    end

    cdoy_conv u_conv
    (
        .req (in_reg),
        .res (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
                in_valid_reg <= s_axis_tvalid;
            if (out_en)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && s_axis_tvalid)
            in_reg <= in_next;
        if (out_en && in_valid_reg)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.day_in_month, out_reg.month_number,
                            out_reg.day_number};
    assign m_axis_tuser  = out_reg.valid_res;

    // A rejected request carries all-zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result with nonzero fields");

    // Only one conversion direction fills fields in a result.
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.day_number == 9'd0 || out_reg.month_number == 4'd0))
        else $error("both day number and month filled");

    // A valid month result also has a nonzero day and a month in range.
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.month_number != 4'd0) |->
            (out_reg.month_number <= 4'd12 && out_reg.day_in_month != 5'd0))
        else $error("month result out of range");

    // A pending request moves to the result register when it has room.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_en) |=> out_valid_reg)
        else $error("request lost between stages");

    // An empty result register never holds back the slave side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule
